// ===== hw/rtl/gqm_pkg.sv =====
`default_nettype none

package gqm_pkg;

  // field widths
  localparam int SymWidth   = 8;
  localparam int ModeWidth  = 2;
  localparam int OutWidth   = 16;
  localparam int LevelWidth = 16;
  localparam int IdxWidth   = SymWidth / 2;
  localparam int LutAddrW   = ModeWidth + IdxWidth;
  localparam int LutDepth   = 1 << LutAddrW;

  // level format: unit amplitude in Q2.30, level in Q1.(LevelWidth-2)
  localparam int UnitFrac  = 30;
  localparam int FracBits  = LevelWidth - 2;
  localparam int RoundSh   = UnitFrac - FracBits;

  typedef enum logic [ModeWidth-1:0] {
    MODE_QPSK   = 2'd0,
    MODE_QAM16  = 2'd1,
    MODE_QAM64  = 2'd2,
    MODE_QAM256 = 2'd3
  } mode_e;

  typedef logic signed [OutWidth-1:0] level_t;
  typedef logic [LutDepth-1:0][OutWidth-1:0] level_tbl_t;

  // unit amplitude per mode: 1/sqrt(2), 1/sqrt(10), 1/sqrt(42), 1/sqrt(170)
  localparam longint unsigned UnitQ30 [4] = '{
    64'd759250125, 64'd339546978, 64'd165681960, 64'd82352239
  };

  // gray-ordered odd multipliers per mode
  localparam int OddQpsk [2]  = '{-1, 1};
  localparam int Odd16   [4]  = '{-1, -3, 1, 3};
  localparam int Odd64   [8]  = '{-3, -1, -5, -7, 3, 1, 5, 7};
  localparam int Odd256  [16] = '{-5, -7, -3, -1, -11, -9, -13, -15,
                                  5, 7, 3, 1, 11, 9, 13, 15};

  function automatic int odd_of(int mode, int idx);
    int res;
    case (mode)
      0:       res = OddQpsk[idx % 2];
      1:       res = Odd16[idx % 4];
      2:       res = Odd64[idx % 8];
      default: res = Odd256[idx % 16];
    endcase
    return res;
  endfunction

  // rounded signed levels for every mode and half-symbol index
  function automatic level_tbl_t build_levels();
    level_tbl_t      tbl;
    int              m;
    int              i;
    int              odd;
    longint unsigned mag;
    longint unsigned r;
    for (m = 0; m < 4; m++) begin
      for (i = 0; i < (1 << IdxWidth); i++) begin
        odd = odd_of(m, i);
        mag = longint'((odd < 0) ? -odd : odd) * UnitQ30[m];
        r   = (mag + (64'd1 << (RoundSh - 1))) >> RoundSh;
        if (odd < 0) begin
          r = 64'd0 - r;
        end
        tbl[m * (1 << IdxWidth) + i] = r[OutWidth-1:0];
      end
    end
    return tbl;
  endfunction

  localparam level_tbl_t LevelTbl = build_levels();

endpackage

`default_nettype wire

// ===== hw/rtl/gqm_sym_if.sv =====
`default_nettype none

interface gqm_sym_if;
  logic                             valid;
  logic                             ready;
  logic [gqm_pkg::SymWidth-1:0]     symbol_bits;
  logic                             last_symbol;

  modport source (output valid, output symbol_bits, output last_symbol, input ready);
  modport sink   (input valid, input symbol_bits, input last_symbol, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/gqm_pt_if.sv =====
`default_nettype none

interface gqm_pt_if;
  logic                                valid;
  logic                                ready;
  logic signed [gqm_pkg::OutWidth-1:0] inphase_level;
  logic signed [gqm_pkg::OutWidth-1:0] quadrature_level;
  logic                                last_out;

  modport source (output valid, output inphase_level, output quadrature_level,
                  output last_out, input ready);
  modport sink   (input valid, input inphase_level, input quadrature_level,
                  input last_out, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/gray_qam_symbol_mapper.sv =====
`default_nettype none

// channel   dir  payload                                          beat
// sym_i     in   symbol_bits[7:0], last_symbol                    one symbol
// pt_o      out  inphase_level[15:0], quadrature_level[15:0],     one point
//                last_out
// cfg       in   cfg_we_i, cfg_wdata_i[1:0] (mode)                one write
//
// two register stages: input register and result register, with the table lookup between them.
// one beat per cycle sustained while pt_o is ready.
// the rate is set by the combinational constant-table lookups between the two registers.
// stalls on pt_o propagate back stage by stage; a full stage holds while stalled, an empty one loads.
// reset clears the stage valids and sets the mode to qpsk.

module gray_qam_symbol_mapper (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  gqm_sym_if.sink                          sym_i,
  gqm_pt_if.source                         pt_o,
  input  logic                             cfg_we_i,
  input  logic [gqm_pkg::ModeWidth-1:0]    cfg_wdata_i
);
  import gqm_pkg::*;

  mode_e                 mode_q;
  logic                  s1_valid_q;
  logic [SymWidth-1:0]   s1_bits_q;
  logic                  s1_last_q;
  logic                  s2_valid_q;
  level_t                s2_i_q;
  level_t                s2_q_q;
  logic                  s2_last_q;
  level_t                i_level;
  level_t                q_level;
  logic                  s2_load;
  logic                  s1_load;

  // mode register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_QPSK;
    end else if (cfg_we_i) begin
      mode_q <= mode_e'(cfg_wdata_i);
    end
  end

  // stage handshake
  assign s2_load   = !s2_valid_q || pt_o.ready;
  assign s1_load   = !s1_valid_q || s2_load;
  assign sym_i.ready = s1_load;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_load) begin
      s1_valid_q <= sym_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_load && sym_i.valid) begin
      s1_bits_q <= sym_i.symbol_bits;
      s1_last_q <= sym_i.last_symbol;
    end
  end

  // level lookup
  gqm_level_lut u_lut (
    .mode_i        (mode_q),
    .symbol_bits_i (s1_bits_q),
    .i_level_o     (i_level),
    .q_level_o     (q_level)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (s2_load) begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_load && s1_valid_q) begin
      s2_i_q    <= i_level;
      s2_q_q    <= q_level;
      s2_last_q <= s1_last_q;
    end
  end

  assign pt_o.valid            = s2_valid_q;
  assign pt_o.inphase_level    = s2_i_q;
  assign pt_o.quadrature_level = s2_q_q;
  assign pt_o.last_out         = s2_last_q;

  // checks
  a_s1_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && s2_load |=> pt_o.valid)
    else $error("stage one beat did not reach the result register");

  a_last_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && s2_load |=> pt_o.last_out == $past(s1_last_q))
    else $error("last flag not carried with its beat");

  a_ready_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !sym_i.ready |-> s1_valid_q && pt_o.valid && !pt_o.ready)
    else $error("input stalled without a full pipe");

  a_level_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pt_o.valid |-> pt_o.inphase_level != '0 && pt_o.quadrature_level != '0)
    else $error("zero constellation level");

endmodule

`default_nettype wire

// ===== hw/rtl/gqm_level_lut.sv =====
`default_nettype none

module gqm_level_lut (
  input  gqm_pkg::mode_e                    mode_i,
  input  logic [gqm_pkg::SymWidth-1:0]      symbol_bits_i,
  output logic signed [gqm_pkg::OutWidth-1:0] i_level_o,
  output logic signed [gqm_pkg::OutWidth-1:0] q_level_o
);
  import gqm_pkg::*;

  logic [IdxWidth-1:0] i_idx;
  logic [IdxWidth-1:0] q_idx;

  // split the used bits into in-phase (upper) and quadrature (lower) halves
  always_comb begin
    case (mode_i)
      MODE_QPSK: begin
        i_idx = {3'b000, symbol_bits_i[1]};
        q_idx = {3'b000, symbol_bits_i[0]};
      end
      MODE_QAM16: begin
        i_idx = {2'b00, symbol_bits_i[3:2]};
        q_idx = {2'b00, symbol_bits_i[1:0]};
      end
      MODE_QAM64: begin
        i_idx = {1'b0, symbol_bits_i[5:3]};
        q_idx = {1'b0, symbol_bits_i[2:0]};
      end
      MODE_QAM256: begin
        i_idx = symbol_bits_i[7:4];
        q_idx = symbol_bits_i[3:0];
      end
      default: begin
        i_idx = '0;
        q_idx = '0;
      end
    endcase
  end

  // constant level table lookup
  assign i_level_o = LevelTbl[{mode_i, i_idx}];
  assign q_level_o = LevelTbl[{mode_i, q_idx}];

endmodule

`default_nettype wire

// ===== test/tb_gray_qam_symbol_mapper.sv =====
`default_nettype none

module tb_gray_qam_symbol_mapper;
  import gqm_pkg::*;

  // run control
  localparam int CycleLimit   = 200000;
  localparam int SettleCycles = 6;
  localparam int SegItems     = 97;
  localparam int MaxReports   = 10;

  // idle and stall percentages per pressure phase
  localparam int SendIdlePct [4] = '{0, 53, 0, 29};
  localparam int SinkStallPct[4] = '{0, 0, 53, 29};

  // unit amplitude per mode in q2.30 and the output fraction
  localparam longint unsigned AmpQ30[4] = '{
    64'd759250125, 64'd339546978, 64'd165681960, 64'd82352239
  };
  localparam int AmpFrac   = 30;
  localparam int LevelFrac = 14;

  // gray-ordered odd multipliers along each axis
  localparam int GrayQpsk[2]    = '{-1, 1};
  localparam int GrayQam16[4]   = '{-1, -3, 1, 3};
  localparam int GrayQam64[8]   = '{-3, -1, -5, -7, 3, 1, 5, 7};
  localparam int GrayQam256[16] = '{-5, -7, -3, -1, -11, -9, -13, -15,
                                    5, 7, 3, 1, 11, 9, 13, 15};

  // levels that can be read straight off the tables
  localparam level_t QpskPos   = 16'sd11585;
  localparam level_t QpskNeg   = -16'sd11585;
  localparam level_t Qam256Max = 16'sd18849;
  localparam level_t Qam256Min = -16'sd18849;

  typedef struct packed {
    level_t inphase;
    level_t quadrature;
    logic   last;
  } point_t;

  typedef struct packed {
    mode_e        mode;
    logic [7:0]   bits;
    logic         last;
    logic         known;
    level_t       want_i;
    level_t       want_q;
  } sym_row_t;

  localparam int NumRows = 22;
  localparam sym_row_t DirectedRows[NumRows] = '{
    // reset mode, used-bit extremes and ignored high bits
    '{MODE_QPSK,   8'h00, 1'b0, 1'b1, QpskNeg,   QpskNeg},
    '{MODE_QPSK,   8'h03, 1'b1, 1'b1, QpskPos,   QpskPos},
    '{MODE_QPSK,   8'hFC, 1'b0, 1'b1, QpskNeg,   QpskNeg},
    '{MODE_QPSK,   8'h02, 1'b0, 1'b1, QpskPos,   QpskNeg},
    '{MODE_QPSK,   8'h01, 1'b1, 1'b1, QpskNeg,   QpskPos},
    '{MODE_QAM16,  8'h00, 1'b0, 1'b0, '0, '0},
    '{MODE_QAM16,  8'h55, 1'b0, 1'b0, '0, '0},
    '{MODE_QAM16,  8'hAA, 1'b0, 1'b0, '0, '0},
    '{MODE_QAM16,  8'hFF, 1'b1, 1'b0, '0, '0},
    '{MODE_QAM16,  8'h0F, 1'b0, 1'b0, '0, '0},
    '{MODE_QAM16,  8'hF0, 1'b0, 1'b0, '0, '0},
    '{MODE_QAM64,  8'h00, 1'b0, 1'b0, '0, '0},
    '{MODE_QAM64,  8'h3F, 1'b0, 1'b0, '0, '0},
    '{MODE_QAM64,  8'hC0, 1'b0, 1'b0, '0, '0},
    '{MODE_QAM64,  8'h2A, 1'b1, 1'b0, '0, '0},
    '{MODE_QAM64,  8'h15, 1'b0, 1'b0, '0, '0},
    '{MODE_QAM256, 8'h77, 1'b0, 1'b1, Qam256Min, Qam256Min},
    '{MODE_QAM256, 8'hFF, 1'b1, 1'b1, Qam256Max, Qam256Max},
    '{MODE_QAM256, 8'h7F, 1'b0, 1'b1, Qam256Min, Qam256Max},
    '{MODE_QAM256, 8'h00, 1'b0, 1'b0, '0, '0},
    '{MODE_QAM256, 8'h88, 1'b0, 1'b0, '0, '0},
    '{MODE_QPSK,   8'hFF, 1'b1, 1'b1, QpskPos,   QpskPos}
  };

  logic  clk_i;
  logic  rst_ni;
  logic  cfg_we_i;
  mode_e cfg_wdata_i;

  gqm_sym_if sym ();
  gqm_pt_if  pt ();

  gray_qam_symbol_mapper u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .sym_i       (sym),
    .pt_o        (pt),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  // predictor state and scoreboard
  mode_e  active_mode;
  point_t pending_points[$];
  logic   drive_known;
  point_t drive_want;
  int     send_idle_pct;
  int     sink_stall_pct;
  int     error_count;
  int     symbols_in;
  int     points_out;
  int     mode_writes;
  int     cycle_count;

  // gray multiplier for one axis index
  function automatic int axis_multiplier(mode_e m, int unsigned idx);
    int mult;
    case (m)
      MODE_QPSK:   mult = GrayQpsk[idx & 1];
      MODE_QAM16:  mult = GrayQam16[idx & 3];
      MODE_QAM64:  mult = GrayQam64[idx & 7];
      default:     mult = GrayQam256[idx & 15];
    endcase
    return mult;
  endfunction

  // odd multiplier times unit amplitude, rounded half away from zero
  function automatic level_t axis_level(mode_e m, int unsigned idx);
    int              mult;
    longint unsigned mag;
    longint unsigned rounded;
    mult    = axis_multiplier(m, idx);
    mag     = longint'((mult < 0) ? -mult : mult) * AmpQ30[m];
    rounded = (mag + (64'd1 << (AmpFrac - LevelFrac - 1))) >> (AmpFrac - LevelFrac);
    if (mult < 0) begin
      rounded = 64'd0 - rounded;
    end
    return level_t'(rounded[15:0]);
  endfunction

  // constellation point for one symbol in the given mode
  function automatic point_t map_symbol(mode_e m, logic [7:0] bits, logic last);
    int unsigned half;
    int unsigned mask;
    point_t      pnt;
    half           = int'(m) + 1;
    mask           = (1 << half) - 1;
    pnt.inphase    = axis_level(m, (int'(bits) >> half) & mask);
    pnt.quadrature = axis_level(m, int'(bits) & mask);
    pnt.last       = last;
    return pnt;
  endfunction

  // clock
  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  // cycle limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("timeout after %0d cycles, %0d points still pending",
               cycle_count, pending_points.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // random backpressure on the point channel
  always @(negedge clk_i) begin
    if (rst_ni) begin
      pt.ready <= ($urandom_range(0, 99) >= sink_stall_pct);
    end
  end

  // scoreboard: check point beats, then record symbol beats
  always @(posedge clk_i) begin : scoreboard
    point_t got;
    point_t want;
    if (rst_ni) begin
      if (pt.valid && pt.ready) begin
        got.inphase    = pt.inphase_level;
        got.quadrature = pt.quadrature_level;
        got.last       = pt.last_out;
        points_out++;
        if (pending_points.size() == 0) begin
          error_count++;
          if (error_count <= MaxReports) begin
            $display("unexpected point beat: i=%0d q=%0d last=%0b",
                     got.inphase, got.quadrature, got.last);
          end
        end else begin
          want = pending_points.pop_front();
          if (got.inphase !== want.inphase || got.quadrature !== want.quadrature ||
              got.last !== want.last) begin
            error_count++;
            if (error_count <= MaxReports) begin
              $display("point mismatch: expected i=%0d q=%0d last=%0b, got i=%0d q=%0d last=%0b",
                       want.inphase, want.quadrature, want.last,
                       got.inphase, got.quadrature, got.last);
            end
          end
        end
      end
      if (sym.valid && sym.ready) begin
        symbols_in++;
        if (drive_known) begin
          pending_points.push_back(drive_want);
        end else begin
          pending_points.push_back(map_symbol(active_mode, sym.symbol_bits, sym.last_symbol));
        end
      end
    end
  end

  // one symbol beat, entered and left at a falling edge
  task automatic drive_symbol(logic [7:0] bits, logic last, logic known,
                              level_t want_i, level_t want_q);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      sym.valid <= 1'b0;
      @(negedge clk_i);
    end
    sym.valid       <= 1'b1;
    sym.symbol_bits <= bits;
    sym.last_symbol <= last;
    drive_known     = known;
    drive_want      = '{inphase: want_i, quadrature: want_q, last: last};
    @(posedge clk_i);
    while (!sym.ready) begin
      @(posedge clk_i);
    end
    @(negedge clk_i);
  endtask

  // mode write once every pending point has drained
  task automatic write_mode(mode_e m);
    sym.valid <= 1'b0;
    while (pending_points.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (SettleCycles) @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= m;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    active_mode = m;
    mode_writes++;
  endtask

  // stimulus
  initial begin
    int       p;
    int       s;
    int       r;
    sym_row_t row;
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_wdata_i     = MODE_QPSK;
    sym.valid       = 1'b0;
    sym.symbol_bits = '0;
    sym.last_symbol = 1'b0;
    pt.ready        = 1'b0;
    active_mode     = MODE_QPSK;
    drive_known     = 1'b0;
    drive_want      = '0;
    send_idle_pct   = 0;
    sink_stall_pct  = 0;
    error_count     = 0;
    symbols_in      = 0;
    points_out      = 0;
    mode_writes     = 0;
    cycle_count     = 0;

    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed rows, reset mode first
    for (r = 0; r < NumRows; r++) begin
      row = DirectedRows[r];
      if (row.mode != active_mode) begin
        write_mode(row.mode);
      end
      drive_symbol(row.bits, row.last, row.known, row.want_i, row.want_q);
    end

    // random symbols, every mode in every pressure phase
    for (p = 0; p < 4; p++) begin
      send_idle_pct  = SendIdlePct[p];
      sink_stall_pct = SinkStallPct[p];
      for (s = 0; s < 4; s++) begin
        write_mode(mode_e'((s + p) % 4));
        repeat (SegItems) begin
          drive_symbol(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                       1'b0, '0, '0);
        end
      end
    end

    // drain
    sym.valid <= 1'b0;
    sink_stall_pct = 0;
    while (pending_points.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (SettleCycles) @(negedge clk_i);

    $display("mapped %0d symbols into %0d points across all four modes, %0d mode writes",
             symbols_in, points_out, mode_writes);
    $display("pressure phases: free flow, idle sender, stalling sink, both; %0d mismatches",
             error_count);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

`default_nettype wire
